@@ src/mslw_pkg.sv @@
`timescale 1ns / 1ps
// Package: shared types and constants of the marshal stream length walker.
package mslw_pkg;

    localparam int unsigned LEN_W = 27;
    localparam int unsigned LIM_W = 20;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       first_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       status;
        logic [LEN_W-1:0] stream_length;
    } t_out_item;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FLAGS    = 3'd1;
    localparam logic [2:0] ST_TRUNC    = 3'd2;
    localparam logic [2:0] ST_WINDOW   = 3'd3;
    localparam logic [2:0] ST_BAD_TYPE = 3'd4;
    localparam logic [2:0] ST_BAD_LEN  = 3'd5;
    localparam logic [2:0] ST_DEEP     = 3'd6;
    localparam logic [2:0] ST_OBJECTS  = 3'd7;

    // Configuration register indexes
    localparam logic CFG_MAX_LENGTH   = 1'b0;
    localparam logic CFG_OBJECT_LIMIT = 1'b1;

    // Frame kinds
    localparam logic [1:0] KIND_ITEMS = 2'd0;
    localparam logic [1:0] KIND_DICT  = 2'd1;
    localparam logic [1:0] KIND_CODE  = 2'd2;

    // Walk phases
    typedef enum logic [2:0] {
        PH_HEADER, PH_TYPE, PH_LEN4, PH_LEN1, PH_SKIP, PH_IDLE
    } t_phase;

    // Type byte classes
    typedef enum logic [3:0] {
        TC_ATOM, TC_SKIP4, TC_SKIP8, TC_SKIP16, TC_LEN4, TC_LEN1,
        TC_DICT, TC_CODE, TC_BAD
    } t_tclass;

    localparam logic [6:0] TY_NULL   = 7'h30;
    localparam logic [6:0] TY_LONG   = 7'h6C;
    localparam logic [6:0] TY_TUPLE1 = 7'h29;
    localparam logic [6:0] TY_CODE   = 7'h63;

    localparam logic [31:0] LONG_MAX_DIGITS = 32'd10000000;
    localparam logic [31:0] STR_MAX_LEN     = 32'd16777216;
    localparam logic [31:0] SEQ_MAX_COUNT   = 32'd4000000;
    localparam logic [5:0]  CODE_TAIL_LEN   = 6'd20;

    function automatic t_tclass classify(input logic [6:0] b);
        t_tclass c;
        case (b)
            7'h30, 7'h4E, 7'h46, 7'h54, 7'h53, 7'h45, 7'h2E, 7'h3F: c = TC_ATOM;
            7'h69, 7'h66, 7'h72: c = TC_SKIP4;
            7'h49, 7'h67: c = TC_SKIP8;
            7'h78, 7'h79: c = TC_SKIP16;
            7'h6C, 7'h73, 7'h75, 7'h61, 7'h41, 7'h28, 7'h5B, 7'h3C, 7'h3E: c = TC_LEN4;
            7'h74, 7'h7A, 7'h5A, 7'h29: c = TC_LEN1;
            7'h7B: c = TC_DICT;
            7'h63: c = TC_CODE;
            default: c = TC_BAD;
        endcase
        return c;
    endfunction

    // Frame control from controller to datapath
    typedef struct packed {
        logic       start;
        logic       load_byte;
        logic       type_op;
        logic       len4_op;
        logic       len1_op;
        logic       skip_op;
        logic       walk_op;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic       busy;
        logic       has_result;
        logic [2:0] status;
    } t_stat;

endpackage

@@ src/mslw_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port-write, single-read RAM with registered read data.
module mslw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and read the array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ src/mslw_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: position, skip and length counters, frame stack and top-frame cache.
module mslw_datapath
    import mslw_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [7:0]       i_byte,
    input  logic [LEN_W-1:0] i_max_length,
    input  logic [LIM_W-1:0] i_object_limit,
    output t_stat            o_stat,
    output logic [LEN_W-1:0] o_position
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int FW = 26;

    t_phase           r_phase, n_phase;
    logic [LEN_W-1:0] r_pos, n_pos;
    logic [FW-1:0]    r_skip, n_skip;
    logic [31:0]      r_acc, n_acc;
    logic [1:0]       r_lidx, n_lidx;
    logic [6:0]       r_pend, n_pend;
    logic [4:0]       r_flags, n_flags;
    logic [DW-1:0]    r_depth, n_depth;
    logic [LIM_W-1:0] r_objs, n_objs;
    logic             r_done, n_done;
    // Top-of-stack frame held in registers; lower frames live in the RAM.
    logic [22:0]      r_left, n_left;
    logic [1:0]       r_kind, n_kind;
    logic             r_tail, n_tail;
    logic             r_walking, n_walking;
    logic             r_pending_pop, n_pending_pop;
    logic             r_res, n_res;
    logic [2:0]       r_st, n_st;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [25:0]      ram_wdata, ram_rdata;

    mslw_ram #(.WIDTH(26), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    logic [27:0] lpos;
    logic [6:0]  tb;
    t_tclass     tc;
    logic [31:0] mag;
    logic [31:0] lv;

    always_comb begin
        n_phase = r_phase; n_pos = r_pos; n_skip = r_skip; n_acc = r_acc;
        n_lidx = r_lidx; n_pend = r_pend; n_flags = r_flags; n_depth = r_depth;
        n_objs = r_objs; n_done = r_done; n_left = r_left; n_kind = r_kind;
        n_tail = r_tail; n_walking = r_walking; n_pending_pop = 1'b0;
        n_res = 1'b0; n_st = r_st;
        ram_we = 1'b0; ram_waddr = AW'(r_depth - DW'(1));
        ram_wdata = {r_left, r_kind, r_tail};
        ram_raddr = AW'(r_depth - DW'(2));
        lpos = {1'b0, r_pos} + 28'(r_skip);
        tb = i_byte[6:0];
        tc = classify(tb);
        mag = r_acc[31] ? (32'd0 - r_acc) : r_acc;
        lv = {i_byte, r_acc[31:8]};

        if (i_cmd.start) begin
            n_phase = PH_HEADER; n_pos = '0; n_skip = '0; n_acc = '0; n_lidx = '0;
            n_pend = '0; n_flags = '0; n_depth = DW'(1); n_objs = '0; n_done = 1'b0;
            n_left = 23'd1; n_kind = KIND_ITEMS; n_tail = 1'b0; n_walking = 1'b0;
        end else if (r_pending_pop) begin
            // Restore the new top frame from the RAM read issued last cycle
            {n_left, n_kind, n_tail} = ram_rdata;
            n_walking = 1'b1;
        end else if (r_walking) begin
            // One step of the post-object walk
            if (lpos >= 28'(i_max_length)) begin
                n_res = 1'b1; n_st = ST_WINDOW; n_walking = 1'b0;
            end else if (r_kind != KIND_DICT && r_left == '0) begin
                if (r_kind == KIND_CODE && !r_tail) begin
                    n_skip = r_skip + FW'(4);
                    n_tail = 1'b1; n_left = 23'd2;
                    if ((lpos + 28'd4) > 28'(i_max_length)) begin
                        n_res = 1'b1; n_st = ST_WINDOW; n_walking = 1'b0;
                    end
                end else begin
                    n_depth = r_depth - DW'(1);
                    if (r_depth == DW'(1)) begin
                        n_done = 1'b1; n_walking = 1'b0;
                        if (r_skip == '0) begin
                            n_res = 1'b1; n_st = ST_OK;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end else begin
                        n_walking = 1'b0; n_pending_pop = 1'b1;
                    end
                end
            end else begin
                n_walking = 1'b0;
                n_phase = (r_skip != '0) ? PH_SKIP : PH_TYPE;
            end
        end else if (i_cmd.load_byte) begin
            n_pos = r_pos + LEN_W'(1);
            case (r_phase)
                PH_HEADER: begin
                    if (r_pos == LEN_W'(4)) n_flags = i_byte[4:0];
                    if (r_pos == LEN_W'(15)) begin
                        if (r_flags != '0) begin
                            n_res = 1'b1; n_st = ST_FLAGS;
                        end else begin
                            n_walking = 1'b1;
                        end
                    end
                end
                PH_TYPE: begin
                    if (r_objs >= i_object_limit) begin
                        n_res = 1'b1; n_st = ST_OBJECTS;
                    end else begin
                        n_objs = r_objs + LIM_W'(1);
                        if (r_kind == KIND_DICT && tb == TY_NULL) begin
                            n_depth = r_depth - DW'(1);
                            if (r_depth == DW'(1)) begin
                                n_res = 1'b1; n_st = ST_DEEP;
                            end else begin
                                n_pending_pop = 1'b1;
                            end
                        end else begin
                            if (r_kind != KIND_DICT && r_left != '0)
                                n_left = r_left - 23'd1;
                            case (tc)
                                TC_ATOM:   n_walking = 1'b1;
                                TC_SKIP4:  begin n_skip = r_skip + FW'(4);  n_walking = 1'b1; end
                                TC_SKIP8:  begin n_skip = r_skip + FW'(8);  n_walking = 1'b1; end
                                TC_SKIP16: begin n_skip = r_skip + FW'(16); n_walking = 1'b1; end
                                TC_LEN4: begin
                                    n_phase = PH_LEN4; n_pend = tb; n_acc = '0; n_lidx = '0;
                                end
                                TC_LEN1: begin
                                    n_phase = PH_LEN1; n_pend = tb;
                                end
                                TC_DICT, TC_CODE: begin
                                    if (r_depth >= DW'(STACK_DEPTH)) begin
                                        n_res = 1'b1; n_st = ST_DEEP;
                                    end else begin
                                        ram_we = 1'b1;
                                        ram_wdata = {n_left, r_kind, r_tail};
                                        n_depth = r_depth + DW'(1);
                                        n_tail = 1'b0;
                                        if (tc == TC_CODE) begin
                                            n_skip = r_skip + FW'(CODE_TAIL_LEN);
                                            n_left = 23'd8; n_kind = KIND_CODE;
                                        end else begin
                                            n_left = '0; n_kind = KIND_DICT;
                                        end
                                        n_walking = 1'b1;
                                    end
                                end
                                default: begin
                                    n_res = 1'b1; n_st = ST_BAD_TYPE;
                                end
                            endcase
                            // After-object window check
                            if (n_walking && (({1'b0, n_pos} + 28'(n_skip)) >
                                              28'(i_max_length))) begin
                                n_walking = 1'b0; n_res = 1'b1; n_st = ST_WINDOW;
                            end
                        end
                    end
                end
                PH_LEN4: begin
                    n_acc = lv;
                    n_lidx = r_lidx + 2'd1;
                    if (r_lidx == 2'd3) begin
                        if (r_pend == TY_LONG) begin
                            mag = lv[31] ? (32'd0 - lv) : lv;
                            if (mag > LONG_MAX_DIGITS) begin
                                n_res = 1'b1; n_st = ST_BAD_LEN;
                            end else begin
                                n_skip = r_skip + FW'({mag[23:0], 2'b00});
                                n_walking = 1'b1;
                            end
                        end else if (r_pend == 7'h73 || r_pend == 7'h75 ||
                                     r_pend == 7'h61 || r_pend == 7'h41) begin
                            if (lv[31] || lv > STR_MAX_LEN) begin
                                n_res = 1'b1; n_st = ST_BAD_LEN;
                            end else begin
                                n_skip = r_skip + FW'(lv[24:0]);
                                n_walking = 1'b1;
                            end
                        end else if (lv[31] || lv > SEQ_MAX_COUNT) begin
                            n_res = 1'b1; n_st = ST_BAD_LEN;
                        end else if (r_depth >= DW'(STACK_DEPTH)) begin
                            n_res = 1'b1; n_st = ST_DEEP;
                        end else begin
                            ram_we = 1'b1;
                            n_depth = r_depth + DW'(1);
                            n_left = lv[22:0]; n_kind = KIND_ITEMS; n_tail = 1'b0;
                            n_walking = 1'b1;
                        end
                        if (n_walking && (({1'b0, n_pos} + 28'(n_skip)) >
                                          28'(i_max_length))) begin
                            n_walking = 1'b0; n_res = 1'b1; n_st = ST_WINDOW;
                        end
                    end
                end
                PH_LEN1: begin
                    if (r_pend == TY_TUPLE1) begin
                        if (r_depth >= DW'(STACK_DEPTH)) begin
                            n_res = 1'b1; n_st = ST_DEEP;
                        end else begin
                            ram_we = 1'b1;
                            n_depth = r_depth + DW'(1);
                            n_left = 23'(i_byte); n_kind = KIND_ITEMS; n_tail = 1'b0;
                            n_walking = 1'b1;
                        end
                    end else begin
                        n_skip = r_skip + FW'(i_byte);
                        n_walking = 1'b1;
                    end
                    if (n_walking && (({1'b0, n_pos} + 28'(n_skip)) >
                                      28'(i_max_length))) begin
                        n_walking = 1'b0; n_res = 1'b1; n_st = ST_WINDOW;
                    end
                end
                PH_SKIP: begin
                    if (r_skip != '0) n_skip = r_skip - FW'(1);
                    if (r_skip <= FW'(1)) begin
                        if (r_done) begin
                            n_res = 1'b1; n_st = ST_OK;
                        end else begin
                            n_phase = PH_TYPE;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (n_res) begin
            n_phase = PH_IDLE; n_walking = 1'b0; n_pending_pop = 1'b0;
        end
    end

    // Hold walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_pos <= '0; r_skip <= '0; r_acc <= '0;
            r_lidx <= '0; r_pend <= '0; r_flags <= '0; r_depth <= DW'(1);
            r_objs <= '0; r_done <= 1'b0; r_left <= 23'd1; r_kind <= KIND_ITEMS;
            r_tail <= 1'b0; r_walking <= 1'b0; r_pending_pop <= 1'b0;
            r_res <= 1'b0; r_st <= ST_OK;
        end else begin
            r_phase <= n_phase; r_pos <= n_pos; r_skip <= n_skip; r_acc <= n_acc;
            r_lidx <= n_lidx; r_pend <= n_pend; r_flags <= n_flags;
            r_depth <= n_depth; r_objs <= n_objs; r_done <= n_done;
            r_left <= n_left; r_kind <= n_kind; r_tail <= n_tail;
            r_walking <= n_walking; r_pending_pop <= n_pending_pop;
            r_res <= n_res; r_st <= n_st;
        end
    end

    assign o_stat.busy       = r_walking | r_pending_pop;
    assign o_stat.has_result = r_res;
    assign o_stat.status     = r_st;
    assign o_position        = r_pos;

    // The op strobes from the controller are not used by the datapath
    logic unused_ops;
    assign unused_ops = i_cmd.type_op ^ i_cmd.len4_op ^ i_cmd.len1_op ^
                        i_cmd.skip_op ^ i_cmd.walk_op;
endmodule

@@ src/mslw_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: handshakes, transaction sequencing and result register.
module mslw_ctrl
    import mslw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in_item         i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output t_out_item        o_item,
    output t_cmd             o_cmd,
    output logic [7:0]       o_byte,
    input  t_stat            i_stat,
    input  logic [LEN_W-1:0] i_position
);
    typedef enum logic [1:0] {S_ACCEPT, S_EXEC, S_RESULT} t_state;

    t_state    r_state;
    logic [7:0] r_byte;
    logic       r_first, r_last, r_idle;
    logic       r_ovalid;
    t_out_item  r_oitem;
    logic       acc;

    assign o_ready = (r_state == S_ACCEPT) && !r_ovalid;
    assign acc = i_valid && o_ready;
    assign o_valid = r_ovalid;
    assign o_item = r_oitem;
    assign o_byte = r_byte;

    always_comb begin
        o_cmd = '0;
        if (r_state == S_EXEC) begin
            o_cmd.start = r_first;
            o_cmd.load_byte = !r_idle || r_first;
            o_cmd.walk_op = 1'b1;
        end
    end

    // Sequence one transaction: latch, execute, settle walk, emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCEPT; r_ovalid <= 1'b0; r_first <= 1'b0;
            r_last <= 1'b0; r_idle <= 1'b0; r_byte <= '0; r_oitem <= '0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_ACCEPT: begin
                    if (acc) begin
                        r_byte <= i_item.byte_value;
                        r_first <= i_item.first_byte;
                        r_last <= i_item.last_byte;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_first) begin
                        r_first <= 1'b0;
                        r_idle <= 1'b0;
                    end else begin
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (i_stat.has_result) begin
                        r_ovalid <= 1'b1;
                        r_oitem.status <= i_stat.status;
                        r_oitem.stream_length <= (i_stat.status == ST_OK) ?
                                                 i_position : '0;
                        r_idle <= 1'b1;
                        r_state <= S_ACCEPT;
                    end else if (!i_stat.busy) begin
                        if (r_last && !r_idle) begin
                            r_ovalid <= 1'b1;
                            r_oitem.status <= ST_TRUNC;
                            r_oitem.stream_length <= '0;
                            r_idle <= 1'b1;
                        end
                        r_state <= S_ACCEPT;
                    end
                end
                default: r_state <= S_ACCEPT;
            endcase
        end
    end
endmodule

@@ src/marshal_stream_length_walker_core.sv @@
`timescale 1ns / 1ps
// Top level: marshal stream length walker core.
// Takes a compiled-bytecode file one byte per transaction, checks the header
// flags and walks the marshal object tree on a frame stack held in a RAM of
// STACK_DEPTH entries. One result is given when the walk ends or fails. Each
// byte is latched, executed and result-checked; no new byte is taken until
// the walk settles and any result is taken. Finished objects add walk steps;
// each popped frame waits for the stack RAM's registered read. The user must
// write configuration only while the block is idle; no logic enforces it.
module marshal_stream_length_walker_core
    import mslw_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in_item   i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out_item  o_data,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [26:0] i_cfg_data
);
    logic [LEN_W-1:0] r_max_length;
    logic [LIM_W-1:0] r_object_limit;
    t_cmd             cmd;
    t_stat            stat;
    logic [7:0]       cur_byte;
    logic [LEN_W-1:0] position;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= LEN_W'(67108864);
            r_object_limit <= LIM_W'(1000000);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_LENGTH:   r_max_length <= i_cfg_data;
                CFG_OBJECT_LIMIT: r_object_limit <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    mslw_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_data),
        .o_cmd(cmd), .o_byte(cur_byte), .i_stat(stat), .i_position(position)
    );

    mslw_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_byte(cur_byte),
        .i_max_length(r_max_length), .i_object_limit(r_object_limit),
        .o_stat(stat), .o_position(position)
    );
endmodule
